// ===== rtl/core/dtg_pkg.sv =====
// dtg_pkg: types, widths, codes and constant tables of the decaying tone generator.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package dtg_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int COS_TABLE_DEPTH = 1024;
    localparam int NOTE_COUNT      = 7;
    localparam int SAMPLE_RATE_HZ  = 44100;

    localparam int PEAK_W     = 15;
    localparam int DECAY_W    = 31;
    localparam int LEN_W      = 24;
    localparam int NOTE_W     = 3;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    localparam int ENV_W      = 32;
    localparam int COS_W      = 16;
    localparam int LUT_BITS   = $clog2(COS_TABLE_DEPTH);
    localparam int COS_AW     = LUT_BITS + 1;
    localparam int MUL_W      = 32;
    localparam int AMP_PROD_W = PEAK_W + COS_W - 1;
    localparam int PROD_W     = AMP_PROD_W + ENV_W - 1;
    localparam int MAG_SHIFT  = 46;
    localparam int MAG_W      = PROD_W - MAG_SHIFT;

    localparam logic [ENV_W-1:0] ENV_ONE = {1'b1, {(ENV_W-1){1'b0}}};

    localparam logic [PEAK_W-1:0]  PEAK_RESET  = PEAK_W'(10000);
    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(2147446153);
    localparam logic [LEN_W-1:0]   LEN_RESET   = LEN_W'(176400);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PEAK   = 2'd0,
        REG_DECAY  = 2'd1,
        REG_LENGTH = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AMP,
        S_ENV,
        S_FINISH,
        S_HOLD
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_AMP,
        OP_ENV,
        OP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_load;
        logic   out_from_calc;
    } t_dp_cmd;

    typedef struct packed {
        logic playing_now;
        logic out_free;
    } t_dp_stat;

    // cosine quarter-wave table, Q1.15, built at elaboration
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [7:0]  HORNER_DEN [1:8] = '{8'd2, 8'd12, 8'd30, 8'd56,
                                                 8'd90, 8'd132, 8'd182, 8'd240};

    typedef logic [COS_W-1:0] t_cos_tab [0:COS_TABLE_DEPTH];

    function automatic logic [COS_W-1:0] f_cos_entry(input int unsigned k);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        x  = (HALF_PI_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int n = 8; n >= 1; n--) begin
            p = ((x2 * t) >> 30) / 64'(HORNER_DEN[n]);
            t = (p > Q30_ONE) ? 64'd0 : (Q30_ONE - p);
        end
        return COS_W'((t + 64'd16384) >> 15);
    endfunction

    function automatic t_cos_tab f_cos_table();
        t_cos_tab tab;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            tab[k] = f_cos_entry(k);
        end
        return tab;
    endfunction

    // per-note phase increments, round half up
    localparam logic [63:0] STEP_DEN = 64'(100 * SAMPLE_RATE_HZ);
    localparam logic [15:0] FREQ_CHZ [0:7] = '{16'd26163, 16'd29366, 16'd32963, 16'd34923,
                                               16'd39200, 16'd44000, 16'd49388, 16'd52325};

    typedef logic [PHASE_BITS-1:0] t_step_tab [0:7];

    function automatic logic [PHASE_BITS-1:0] f_step(input logic [15:0] chz);
        logic [63:0] r;
        logic [63:0] q;
        r = 64'(chz) % STEP_DEN;
        q = 64'(chz) / STEP_DEN;
        for (int b = 0; b < PHASE_BITS; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= STEP_DEN) begin
                r = r - STEP_DEN;
                q = q | 64'd1;
            end
        end
        if ((r << 1) >= STEP_DEN) begin
            q = q + 64'd1;
        end
        return q[PHASE_BITS-1:0];
    endfunction

    function automatic t_step_tab f_step_table();
        t_step_tab tab;
        for (int i = 0; i < 8; i++) begin
            tab[i] = f_step(FREQ_CHZ[i]);
        end
        return tab;
    endfunction

    localparam t_step_tab NOTE_STEP = f_step_table();

endpackage

// ===== rtl/core/dtg_if.sv =====
// dtg_if: valid/ready channel interfaces of the tone generator (tick in, sample out,
// register write). Depends on dtg_pkg for field widths.
`timescale 1ns / 1ps

interface dtg_in_if import dtg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              start_req;
    logic [NOTE_W-1:0] note;

    modport source (output valid, output start_req, output note, input ready);
    modport sink   (input valid, input start_req, input note, output ready);
endinterface

interface dtg_out_if import dtg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

interface dtg_cfg_if import dtg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/decaying_tone_generator_top.sv =====
// decaying_tone_generator_top: top level; joins the controller and the datapath to the
// tick, sample and register channels. Depends on dtg_pkg, dtg_if, dtg_ctrl, dtg_datapath.
//
//   port    dir  modport  word
//   i_in    in   sink     start_req, note        (one sample tick)
//   o_out   out  source   sample, last           (one PCM sample)
//   i_cfg   in   sink     index, data            (register write, always ready)
//
// A playing tick is accepted with a cosine ROM read, then makes three passes through
// the one shared 32x32 multiplier (amplitude x cosine, x envelope, envelope decay).
// An idle tick goes to the hold state. A finished word sits in the output register
// while the next tick is taken; a second word waits in a hold state until it drains.
// Reset is synchronous; the cosine and step tables are constant, no clearing pass.
`timescale 1ns / 1ps

module decaying_tone_generator_top import dtg_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dtg_in_if.sink          i_in,
    dtg_out_if.source       o_out,
    dtg_cfg_if.sink         i_cfg
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign i_cfg.ready = 1'b1;

    dtg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    dtg_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_start_req (i_in.start_req),
        .i_note      (i_in.note),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_sample    (o_out.sample),
        .o_last      (o_out.last)
    );

endmodule

// ===== rtl/core/dtg_ctrl.sv =====
// dtg_ctrl: sequencing state machine of the tone generator; issues datapath commands.
// Depends on dtg_pkg (state and command types).
`timescale 1ns / 1ps

module dtg_ctrl import dtg_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state             = r_state;
        o_in_ready          = 1'b0;
        o_cmd.op            = OP_NONE;
        o_cmd.out_load      = 1'b0;
        o_cmd.out_from_calc = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                    n_state  = i_stat.playing_now ? S_AMP : S_HOLD;
                end
            end
            S_AMP: begin
                o_cmd.op = OP_AMP;
                n_state  = S_ENV;
            end
            S_ENV: begin
                o_cmd.op = OP_ENV;
                n_state  = S_FINISH;
            end
            S_FINISH: begin
                o_cmd.op = OP_FINISH;
                if (i_stat.out_free) begin
                    o_cmd.out_load      = 1'b1;
                    o_cmd.out_from_calc = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_stat.out_free)
        else $error("output loaded while previous word still pending");

    a_finish_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && !i_stat.out_free) |=> (r_state == S_HOLD))
        else $error("finished sample not parked while output stalled");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_stat.playing_now) |=> (r_state == S_HOLD))
        else $error("idle tick did not go straight to output");
`endif

endmodule

// ===== rtl/core/dtg_datapath.sv =====
// dtg_datapath: registers, cosine ROM, shared 32x32 multiplier and output register.
// Depends on dtg_pkg (tables, widths, command and status types).
`timescale 1ns / 1ps

module dtg_datapath import dtg_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic                       i_start_req,
    input  logic [NOTE_W-1:0]          i_note,
    input  logic                       i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_sample,
    output logic                       o_last
);

    localparam t_cos_tab COS_TAB = f_cos_table();
    localparam logic [COS_AW-1:0] COS_DEPTH_A = COS_AW'(COS_TABLE_DEPTH);

    logic [PEAK_W-1:0]     r_peak;
    logic [DECAY_W-1:0]    r_decay;
    logic [LEN_W-1:0]      r_len;

    logic [PHASE_BITS-1:0] r_phase;
    logic [ENV_W-1:0]      r_env;
    logic [LEN_W-1:0]      r_idx;
    logic [NOTE_W-1:0]     r_note;
    logic                  r_playing;

    logic [COS_W-1:0]      r_cos;
    logic                  r_neg;
    logic [PROD_W-1:0]     r_prod;

    logic [SAMPLE_W-1:0]   r_res_sample;
    logic                  r_res_last;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_out_sample;
    logic                  r_out_last;

    logic [NOTE_W-1:0]     w_note_sat;
    logic [PHASE_BITS-1:0] w_phase_rd;
    logic [1:0]            w_quad;
    logic [LUT_BITS-1:0]   w_k;
    logic [COS_AW-1:0]     w_addr;
    logic [MUL_W-1:0]      w_mul_a;
    logic [MUL_W-1:0]      w_mul_b;
    logic [2*MUL_W-1:0]    w_mul;
    logic [SAMPLE_W-1:0]   w_mag;
    logic [SAMPLE_W-1:0]   w_sample;
    logic [LEN_W:0]        w_idx_inc;
    logic                  w_last;

    assign o_stat.playing_now = r_playing | i_start_req;
    assign o_stat.out_free    = !r_out_valid || i_out_ready;

    assign w_note_sat = ({1'b0, i_note} >= (NOTE_W+1)'(NOTE_COUNT)) ?
                        NOTE_W'(NOTE_COUNT - 1) : i_note;

    // lookup phase: a start clears it for this very tick
    assign w_phase_rd = i_start_req ? '0 : r_phase;
    assign w_quad     = w_phase_rd[PHASE_BITS-1 -: 2];
    assign w_k        = w_phase_rd[PHASE_BITS-3 -: LUT_BITS];
    assign w_addr     = w_quad[0] ? (COS_DEPTH_A - {1'b0, w_k}) : {1'b0, w_k};

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.op)
            OP_AMP: begin
                w_mul_a = MUL_W'(r_peak);
                w_mul_b = MUL_W'(r_cos);
            end
            OP_ENV: begin
                w_mul_a = MUL_W'(r_prod[AMP_PROD_W-1:0]);
                w_mul_b = r_env;
            end
            OP_FINISH: begin
                w_mul_a = r_env;
                w_mul_b = MUL_W'(r_decay);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul = (2*MUL_W)'(w_mul_a) * (2*MUL_W)'(w_mul_b);

    // envelope never exceeds 1.0, so the magnitude fits 15 bits
    assign w_mag     = SAMPLE_W'(r_prod[PROD_W-1 -: MAG_W]);
    assign w_sample  = r_neg ? (SAMPLE_W'(0) - w_mag) : w_mag;
    assign w_idx_inc = {1'b0, r_idx} + 1'b1;
    assign w_last    = w_idx_inc >= {1'b0, r_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak  <= PEAK_RESET;
            r_decay <= DECAY_RESET;
            r_len   <= LEN_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PEAK:   r_peak  <= i_cfg_data[PEAK_W-1:0];
                REG_DECAY:  r_decay <= i_cfg_data[DECAY_W-1:0];
                REG_LENGTH: r_len   <= i_cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_env     <= '0;
            r_idx     <= '0;
            r_note    <= '0;
            r_playing <= 1'b0;
        end else if (i_cmd.op == OP_ACCEPT) begin
            if (i_start_req) begin
                r_phase   <= '0;
                r_env     <= ENV_ONE;
                r_idx     <= '0;
                r_note    <= w_note_sat;
                r_playing <= 1'b1;
            end
        end else if (i_cmd.op == OP_FINISH) begin
            if (w_last) begin
                r_playing <= 1'b0;
            end else begin
                r_idx   <= w_idx_inc[LEN_W-1:0];
                r_phase <= r_phase + NOTE_STEP[r_note];
                r_env   <= w_mul[DECAY_W +: ENV_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT) begin
            r_cos        <= COS_TAB[w_addr];
            r_neg        <= w_quad[1] ^ w_quad[0];
            r_res_sample <= '0;
            r_res_last   <= 1'b0;
        end
        if (i_cmd.op == OP_AMP || i_cmd.op == OP_ENV) begin
            r_prod <= w_mul[PROD_W-1:0];
        end
        if (i_cmd.op == OP_FINISH) begin
            r_res_sample <= w_sample;
            r_res_last   <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= i_cmd.out_from_calc ? w_sample : r_res_sample;
            r_out_last   <= i_cmd.out_from_calc ? w_last : r_res_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_out_sample;
    assign o_last      = r_out_last;

`ifndef ASSERT_OFF
    a_env_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env <= ENV_ONE)
        else $error("envelope above 1.0");

    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_FINISH && w_last) |=> !r_playing)
        else $error("note kept playing after its last sample");

    a_start_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == OP_ACCEPT && i_start_req) |=> (r_env == ENV_ONE && r_playing))
        else $error("start did not load the envelope");
`endif

endmodule

// ===== test/decaying_tone_generator_top_tb.sv =====
// decaying_tone_generator_top_tb: self-checking bench for the decaying tone generator.
// Drives ticks and register writes, predicts or tables PCM words, checks them in order.
// Depends on dtg_pkg, dtg_if and the decaying_tone_generator_top RTL.
`timescale 1ns / 1ps

module decaying_tone_generator_top_tb;
    import dtg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;
    localparam int unsigned RANDOM_TICKS   = 650;
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned NOTE_CENTIHZ [8] = '{26163, 29366, 32963, 34923,
                                                 39200, 44000, 49388, 52325};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_pcm_word;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  start;
        logic [NOTE_W-1:0]     note;
        logic                  typed;
        t_pcm_word             word;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 29;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd7, 1'b1, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd0, 1'b1, '{16'sd10000, 1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd5, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd2, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_PEAK,   31'd32767,      1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd7, 1'b1, '{16'sd32767, 1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_LENGTH, 31'd0,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd1, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd3, 1'b1, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd1, 1'b1, '{16'sd32767, 1'b1}},
        '{ROW_WRITE, REG_PEAK,   31'd0,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd2, 1'b1, '{16'sd0,     1'b1}},
        '{ROW_WRITE, REG_LENGTH, 31'd1,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_PEAK,   31'd12345,      1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd4, 1'b1, '{16'sd12345, 1'b1}},
        '{ROW_WRITE, REG_LENGTH, 31'd16777215,   1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DECAY,  31'd0,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd5, 1'b1, '{16'sd12345, 1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd0, 1'b1, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_DECAY,  31'h7FFF_FFFF,  1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd6, 1'b1, '{16'sd12345, 1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd6, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b1, 3'd3, 1'b1, '{16'sd12345, 1'b0}},
        '{ROW_WRITE, REG_NONE,   31'h7FFF_FFFF,  1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_WRITE, REG_LENGTH, 31'd3,          1'b0, 3'd0, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd7, 1'b0, '{16'sd0,     1'b0}},
        '{ROW_TICK,  REG_NONE,   31'd0,          1'b0, 3'd4, 1'b0, '{16'sd0,     1'b0}}
    };

    logic i_clk;
    logic i_rst_n;

    dtg_in_if  tick_if ();
    dtg_out_if pcm_if ();
    dtg_cfg_if cfg_if ();

    decaying_tone_generator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_if),
        .o_out   (pcm_if),
        .i_cfg   (cfg_if)
    );

    // predictor state
    logic [COS_W-1:0]      cos_q15 [0:COS_TABLE_DEPTH];
    logic [PHASE_BITS-1:0] note_inc [8];
    logic [PEAK_W-1:0]     cfg_peak;
    logic [DECAY_W-1:0]    cfg_decay;
    logic [LEN_W-1:0]      cfg_len;
    logic [PHASE_BITS-1:0] tone_phase;
    logic [ENV_W-1:0]      tone_env;
    logic [LEN_W-1:0]      tone_count;
    logic [NOTE_W-1:0]     tone_note;
    logic                  tone_on;

    t_pcm_word   pending_samples [$];
    t_pcm_word   want;
    int unsigned err_count;
    int unsigned quiet_cycles;
    bit          steady;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic build_tone_tables();
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint          t;
        longint unsigned den;
        for (int k = 0; k <= COS_TABLE_DEPTH; k++) begin
            x  = (HALF_PI_Q30 * longint'(k)) / longint'(COS_TABLE_DEPTH);
            x2 = (x * x) >> 30;
            t  = longint'(Q30_ONE);
            for (int n = 8; n >= 1; n--) begin
                den = longint'((2 * n - 1) * (2 * n));
                p   = ((x2 * longint'(t)) >> 30) / den;
                t   = longint'(Q30_ONE) - longint'(p);
                if (t < 0) t = 0;
            end
            cos_q15[k] = COS_W'((t + 16384) >> 15);
        end
        // round half up of f * 2^PHASE_BITS / rate, f in hundredths of a Hz
        den = longint'(100 * SAMPLE_RATE_HZ);
        for (int i = 0; i < 8; i++) begin
            x = (longint'(NOTE_CENTIHZ[i]) << (PHASE_BITS + 1)) + den;
            note_inc[i] = PHASE_BITS'(x / (2 * den));
        end
    endtask

    function automatic t_pcm_word synth_tick(input logic start, input logic [NOTE_W-1:0] sel);
        logic [LUT_BITS+1:0]   lut_i;
        logic [LUT_BITS-1:0]   k;
        logic [COS_W-1:0]      mag;
        logic                  neg;
        logic [63:0]           m;
        t_pcm_word             w;
        w = '0;
        if (start) begin
            tone_note  = (sel >= NOTE_COUNT) ? NOTE_W'(NOTE_COUNT - 1) : sel;
            tone_phase = '0;
            tone_env   = ENV_ONE;
            tone_count = '0;
            tone_on    = 1'b1;
        end
        if (tone_on) begin
            lut_i = tone_phase[PHASE_BITS-1 -: LUT_BITS+2];
            k     = lut_i[LUT_BITS-1:0];
            case (lut_i[LUT_BITS+1:LUT_BITS])
                2'd0: begin mag = cos_q15[k];                   neg = 1'b0; end
                2'd1: begin mag = cos_q15[COS_TABLE_DEPTH - k]; neg = 1'b1; end
                2'd2: begin mag = cos_q15[k];                   neg = 1'b1; end
                default: begin mag = cos_q15[COS_TABLE_DEPTH - k]; neg = 1'b0; end
            endcase
            m = (64'(cfg_peak) * 64'(tone_env) * 64'(mag)) >> MAG_SHIFT;
            if (neg) w.sample = (m > 64'd32768) ? -16'sd32768 : SAMPLE_W'(64'd0 - m);
            else     w.sample = (m > 64'd32767) ? 16'sd32767 : SAMPLE_W'(m);
            if ({1'b0, tone_count} + 25'd1 >= {1'b0, cfg_len}) begin
                w.last  = 1'b1;
                tone_on = 1'b0;
            end else begin
                tone_count = tone_count + 1'b1;
                tone_phase = tone_phase + note_inc[tone_note];
                tone_env   = ENV_W'((64'(tone_env) * 64'(cfg_decay)) >> 31);
            end
        end
        return w;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic flag_mismatch(input string field, input int got, input int exp_val);
        $display("ERROR %0t: %s got %0d expected %0d", $time, field, got, exp_val);
        err_count++;
    endtask

    // called at a falling edge; returns at a falling edge
    task automatic drain_results();
        tick_if.valid = 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        drain_results();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            REG_PEAK:   cfg_peak  = value[PEAK_W-1:0];
            REG_DECAY:  cfg_decay = value[DECAY_W-1:0];
            REG_LENGTH: cfg_len   = value[LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic send_tick(input logic start, input logic [NOTE_W-1:0] sel,
                             input logic typed, input t_pcm_word typed_word);
        int unsigned gap;
        t_pcm_word   w;
        gap = pick_gap();
        if (gap != 0) begin
            tick_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_if.valid     = 1'b1;
        tick_if.start_req = start;
        tick_if.note      = sel;
        @(posedge i_clk);
        while (!tick_if.ready) @(posedge i_clk);
        w = synth_tick(start, sel);
        pending_samples.push_back(typed ? typed_word : w);
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned stall;
        pcm_if.ready = 1'b0;
        forever begin
            stall = pick_gap();
            if (stall != 0) begin
                pcm_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pcm_if.ready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pcm_if.valid && pcm_if.ready) begin
            if (pending_samples.size() == 0) begin
                flag_mismatch("unexpected word, sample", int'(pcm_if.sample), 0);
            end else begin
                want = pending_samples.pop_front();
                if (pcm_if.sample !== want.sample)
                    flag_mismatch("sample", int'(pcm_if.sample), int'(want.sample));
                if (pcm_if.last !== want.last)
                    flag_mismatch("last", int'(pcm_if.last), int'(want.last));
            end
        end
        if ((tick_if.valid && tick_if.ready) || (pcm_if.valid && pcm_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("decaying_tone_generator_top test failed");
            $finish;
        end
    end

    initial begin
        int unsigned sent_ticks;
        int unsigned phase_len;
        int unsigned r;
        logic        do_start;
        i_rst_n           = 1'b0;
        tick_if.valid     = 1'b0;
        tick_if.start_req = 1'b0;
        tick_if.note      = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = '0;
        cfg_if.data       = '0;
        err_count         = 0;
        quiet_cycles      = 0;
        steady            = 1'b0;
        sent_ticks        = 0;
        build_tone_tables();
        cfg_peak   = PEAK_W'(10000);
        cfg_decay  = DECAY_W'(2147446153);
        cfg_len    = LEN_W'(176400);
        tone_phase = '0;
        tone_env   = '0;
        tone_count = '0;
        tone_note  = '0;
        tone_on    = 1'b0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (DIRECTED[i].kind == ROW_WRITE)
                write_register(DIRECTED[i].idx, DIRECTED[i].data);
            else
                send_tick(DIRECTED[i].start, DIRECTED[i].note, DIRECTED[i].typed,
                          DIRECTED[i].word);
        end

        while (sent_ticks < RANDOM_TICKS) begin
            steady = 1'b0;
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0: write_register(REG_PEAK, 31'd0);
                    1: write_register(REG_PEAK, 31'd32767);
                    default: write_register(REG_PEAK, CFG_DATA_W'($urandom_range(0, 32767)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 9))
                    0: write_register(REG_DECAY, 31'd0);
                    1: write_register(REG_DECAY, 31'h7FFF_FFFF);
                    2, 3: write_register(REG_DECAY, 31'd2147446153);
                    4: write_register(REG_DECAY, CFG_DATA_W'($urandom));
                    default: write_register(REG_DECAY,
                        CFG_DATA_W'($urandom_range(32'h7FC0_0000, 32'h7FFF_FFFF)));
                endcase
            end
            if ($urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 19))
                    0: write_register(REG_LENGTH, 31'd0);
                    1: write_register(REG_LENGTH, 31'd1);
                    2: write_register(REG_LENGTH, CFG_DATA_W'($urandom_range(1000, 16777215)));
                    default: write_register(REG_LENGTH, CFG_DATA_W'($urandom_range(2, 40)));
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                write_register(REG_NONE, CFG_DATA_W'($urandom));

            steady    = ($urandom_range(0, 4) == 0);
            phase_len = $urandom_range(20, 60);
            repeat (phase_len) begin
                r = $urandom_range(0, 99);
                do_start = tone_on ? (r < 5) : (r < 60);
                if ($urandom_range(0, 49) == 0) drain_results();
                sent_ticks++;
                send_tick(do_start, NOTE_W'($urandom_range(0, 7)), 1'b0, '0);
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (20) @(negedge i_clk);
        if (err_count == 0 && pending_samples.size() == 0) begin
            $display("decaying_tone_generator_top test passed");
        end else begin
            $display("decaying_tone_generator_top test failed");
        end
        $finish;
    end

endmodule
